// File: hdl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also holds while reset is asserted
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/cdcw_pkg.sv
// types, constants and table functions for the date check and weekday block
`default_nettype none
package cdcw_pkg;

  localparam logic [11:0] YEAR_MIN   = 12'd2000;
  localparam logic [11:0] YEAR_MAX   = 12'd2099;
  localparam logic [3:0]  MONTH_MIN  = 4'd1;
  localparam logic [3:0]  MONTH_MAX  = 4'd12;
  localparam logic [3:0]  MONTH_FEB  = 4'd2;
  localparam logic [4:0]  HOUR_MAX   = 5'd23;
  localparam logic [5:0]  MINUTE_MAX = 6'd59;
  localparam logic [5:0]  SECOND_MAX = 6'd59;
  localparam logic [2:0]  DOW_MOD    = 3'd7;
  localparam logic [2:0]  DOW_SUNDAY = 3'd7;
  localparam logic [2:0]  DOW_NONE   = 3'd0;

  typedef struct packed {
    logic       date_ok;
    logic [2:0] weekday;
  } date_res_t;

  // days in month, leap february included
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // (26*shifted_month - 2) / 10 reduced modulo 7, indexed by calendar month
  function automatic logic [2:0] month_term(input logic [3:0] m);
    logic [2:0] t;
    unique case (m)
      4'd1:    t = 3'd0;
      4'd2:    t = 3'd3;
      4'd3:    t = 3'd2;
      4'd4:    t = 3'd5;
      4'd5:    t = 3'd0;
      4'd6:    t = 3'd3;
      4'd7:    t = 3'd5;
      4'd8:    t = 3'd1;
      4'd9:    t = 3'd4;
      4'd10:   t = 3'd6;
      4'd11:   t = 3'd2;
      4'd12:   t = 3'd4;
      default: t = 3'd0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// File: hdl/cdcw_date.sv
// date range check and weekday from the gauss congruence
`default_nettype none
module cdcw_date (
  input  wire logic [11:0]        year,
  input  wire logic [3:0]         month,
  input  wire logic [4:0]         day_of_month,
  output      cdcw_pkg::date_res_t res
);
  import cdcw_pkg::*;

  logic       leap;
  logic       year_in;
  logic       month_in;
  logic       day_in;
  logic [4:0] len;
  logic [11:0] year_diff;
  logic [6:0] yo;
  logic       early;
  logic [6:0] yy;
  logic       cc_adj;
  logic [7:0] sum;
  logic [6:0] fold1;
  logic [3:0] fold2;
  logic [3:0] fold3;
  logic [2:0] dow;

  assign leap     = (year[1:0] == 2'b00);
  assign year_in  = (year >= YEAR_MIN) && (year <= YEAR_MAX);
  assign month_in = (month >= MONTH_MIN) && (month <= MONTH_MAX);
  assign len      = month_len(month, leap);
  assign day_in   = (day_of_month != 5'd0) && (day_of_month <= len);

  // years inside the window only; century term is 0 mod 7 for 20xx, 1 for 1999
  assign year_diff = year - YEAR_MIN;
  assign yo        = year_diff[6:0];
  assign early     = (month <= MONTH_FEB);

  always_comb begin
    yy     = yo;
    cc_adj = 1'b0;
    if (early) begin
      if (yo == 7'd0) begin
        yy     = 7'd99;
        cc_adj = 1'b1;
      end else begin
        yy = yo - 7'd1;
      end
    end
  end

  assign sum = {3'b000, day_of_month} + {5'b00000, month_term(month)}
             + {1'b0, yy} + {3'b000, yy[6:2]} + {7'b0000000, cc_adj};

  // mod 7 by folding: 64 and 8 are both 1 mod 7
  assign fold1 = {5'b00000, sum[7:6]} + {1'b0, sum[5:0]};
  assign fold2 = fold1[6:3] + {1'b0, fold1[2:0]};
  assign fold3 = {3'b000, fold2[3]} + {1'b0, fold2[2:0]};

  always_comb begin
    if (fold3 >= {1'b0, DOW_MOD}) begin
      dow = fold3[2:0] - DOW_MOD;
    end else begin
      dow = fold3[2:0];
    end
  end

  always_comb begin
    res.date_ok = year_in && month_in && day_in;
    if (res.date_ok) begin
      res.weekday = (dow == 3'd0) ? DOW_SUNDAY : dow;
    end else begin
      res.weekday = DOW_NONE;
    end
  end

endmodule
`default_nettype wire

// File: hdl/cdcw_time.sv
// time of day range check
`default_nettype none
module cdcw_time (
  input  wire logic [4:0] hour,
  input  wire logic [5:0] minute,
  input  wire logic [5:0] second,
  output      logic       time_ok
);
  import cdcw_pkg::*;

  assign time_ok = (hour <= HOUR_MAX) && (minute <= MINUTE_MAX) && (second <= SECOND_MAX);

endmodule
`default_nettype wire

// File: hdl/calendar_date_check_weekday_top.sv
// calendar date and time check with weekday: input register, check logic, result register
// an input transfer is captured in the input register, and its result in the result register
// throughput: one item per cycle while the output is not stalled
// stall from the output reaches in_stall only when both registers hold an item
// rst (synchronous, active high) empties both registers; no other state
`default_nettype none
module calendar_date_check_weekday_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [11:0] year,
  input  wire logic [3:0]  month,
  input  wire logic [4:0]  day_of_month,
  input  wire logic [4:0]  hour,
  input  wire logic [5:0]  minute,
  input  wire logic [5:0]  second,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic        date_ok,
  output      logic        time_ok,
  output      logic [2:0]  weekday
);
  import cdcw_pkg::*;

`include "assert_macros.svh"

  logic        s1_valid;
  logic [11:0] s1_year;
  logic [3:0]  s1_month;
  logic [4:0]  s1_day;
  logic [4:0]  s1_hour;
  logic [5:0]  s1_minute;
  logic [5:0]  s1_second;
  logic        s2_hold;
  logic        s1_hold;
  logic        in_xfer;
  date_res_t   date_res;
  logic        time_res;

  assign s2_hold  = out_valid && out_stall;
  assign s1_hold  = s1_valid && s2_hold;
  assign in_stall = s1_hold;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_hold) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_year   <= year;
      s1_month  <= month;
      s1_day    <= day_of_month;
      s1_hour   <= hour;
      s1_minute <= minute;
      s1_second <= second;
    end
  end

  cdcw_date u_date (
    .year         (s1_year),
    .month        (s1_month),
    .day_of_month (s1_day),
    .res          (date_res)
  );

  cdcw_time u_time (
    .hour    (s1_hour),
    .minute  (s1_minute),
    .second  (s1_second),
    .time_ok (time_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!s2_hold) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && !s2_hold) begin
      date_ok <= date_res.date_ok;
      time_ok <= time_res;
      weekday <= date_res.weekday;
    end
  end

  `ASSERT_CLK(a_bad_date_no_day, (out_valid && !date_ok) |-> (weekday == DOW_NONE), "weekday set for invalid date")
  `ASSERT_CLK(a_good_date_day, (out_valid && date_ok) |-> (weekday != DOW_NONE), "no weekday for valid date")
  `ASSERT_ALWAYS(a_stall_full, in_stall |-> (s1_valid && out_valid && out_stall), "input stalled with room")
  `ASSERT_CLK(a_xfer_lands, in_xfer |=> s1_valid, "input transfer lost")

endmodule
`default_nettype wire

// File: sim/tb_top.sv
// testbench for calendar_date_check_weekday_top: date, time and weekday checks
`timescale 1ns / 100ps

module tb_top;
  import cdcw_pkg::*;

  typedef struct packed {
    logic       date_ok;
    logic       time_ok;
    logic [2:0] weekday;
  } date_check_t;

  logic        clk;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [11:0] year         = '0;
  logic [3:0]  month        = '0;
  logic [4:0]  day_of_month = '0;
  logic [4:0]  hour         = '0;
  logic [5:0]  minute       = '0;
  logic [5:0]  second       = '0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic        date_ok;
  logic        time_ok;
  logic [2:0]  weekday;

  date_check_t date_checks_q[$];
  date_check_t want_chk;
  int          n_mismatch = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  int          rx_hold    = 0;

  calendar_date_check_weekday_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .hour         (hour),
    .minute       (minute),
    .second       (second),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .date_ok      (date_ok),
    .time_ok      (time_ok),
    .weekday      (weekday)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("calendar_date_check_weekday_top: mismatch");
    $finish;
  end

  function automatic logic [4:0] days_per_month(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // gauss congruence, jan and feb belong to the prior year; 0 maps to sunday
  function automatic logic [2:0] zeller_weekday(input int unsigned y, input int unsigned m,
                                                input int unsigned d);
    int unsigned sm, ay, yy, cc, sum, dow;
    if (m > 2) begin
      sm = m - 2;
      ay = y;
    end else begin
      sm = m + 10;
      ay = y - 1;
    end
    yy  = ay % 100;
    cc  = ay / 100;
    sum = d + (sm * 26 - 2) / 10 + yy + yy / 4 + cc / 4 + 5 * cc;
    dow = sum % 7;
    return (dow == 0) ? DOW_SUNDAY : 3'(dow);
  endfunction

  function automatic date_check_t predict_date_check(
    input logic [11:0] y, input logic [3:0] m, input logic [4:0] d,
    input logic [4:0] h, input logic [5:0] mi, input logic [5:0] s);
    date_check_t r;
    logic [4:0]  len;
    len       = days_per_month(m, y[1:0] == 2'd0);
    r.date_ok = (y >= YEAR_MIN) && (y <= YEAR_MAX) && (m >= MONTH_MIN) && (m <= MONTH_MAX)
                && (d >= 5'd1) && (d <= len);
    r.time_ok = (h <= HOUR_MAX) && (mi <= MINUTE_MAX) && (s <= SECOND_MAX);
    r.weekday = r.date_ok ? zeller_weekday(32'(y), 32'(m), 32'(d)) : DOW_NONE;
    return r;
  endfunction

  // one input transfer; called at a rising edge, returns at the accepting edge
  task automatic send_date(input logic [11:0] y, input logic [3:0] m, input logic [4:0] d,
                           input logic [4:0] h, input logic [5:0] mi, input logic [5:0] s);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    year         <= y;
    month        <= m;
    day_of_month <= d;
    hour         <= h;
    minute       <= mi;
    second       <= s;
    do @(posedge clk); while (in_stall);
    date_checks_q.push_back(predict_date_check(y, m, d, h, mi, s));
  endtask

  task automatic send_valid_date();
    logic [11:0] y;
    logic [3:0]  m;
    logic [4:0]  h;
    logic [5:0]  mi, s;
    y = 12'($urandom_range(YEAR_MIN, YEAR_MAX));
    m = 4'($urandom_range(MONTH_MIN, MONTH_MAX));
    // mostly valid times, now and then one out of range
    if ($urandom_range(0, 7) == 0) begin
      h  = 5'($urandom);
      mi = 6'($urandom);
      s  = 6'($urandom);
    end else begin
      h  = 5'($urandom_range(0, HOUR_MAX));
      mi = 6'($urandom_range(0, MINUTE_MAX));
      s  = 6'($urandom_range(0, SECOND_MAX));
    end
    send_date(y, m, 5'($urandom_range(1, days_per_month(m, y[1:0] == 2'd0))), h, mi, s);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (date_checks_q.size() != 0) @(posedge clk);
  endtask

  task automatic shuffle_idling();
    tx_idle_en = ($urandom_range(0, 3) != 0);
    rx_idle_en = ($urandom_range(0, 3) != 0);
  endtask

  task automatic test_directed();
    send_date(12'd0,    4'd0,  5'd0,  5'd0,  6'd0,  6'd0);
    send_date(12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);
    send_date(12'd2000, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0);
    send_date(12'd2000, 4'd2,  5'd29, 5'd23, 6'd59, 6'd59);
    send_date(12'd2001, 4'd2,  5'd29, 5'd12, 6'd30, 6'd30);
    send_date(12'd2001, 4'd2,  5'd28, 5'd12, 6'd30, 6'd30);
    send_date(12'd2024, 4'd2,  5'd30, 5'd1,  6'd1,  6'd1);
    send_date(12'd2099, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
    send_date(12'd2100, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0);
    send_date(12'd1999, 4'd12, 5'd31, 5'd0,  6'd0,  6'd0);
    send_date(12'd2023, 4'd1,  5'd1,  5'd8,  6'd15, 6'd45);
    send_date(12'd2024, 4'd4,  5'd31, 5'd10, 6'd10, 6'd10);
    send_date(12'd2024, 4'd4,  5'd30, 5'd10, 6'd10, 6'd10);
    send_date(12'd2050, 4'd0,  5'd10, 5'd5,  6'd5,  6'd5);
    send_date(12'd2050, 4'd13, 5'd10, 5'd5,  6'd5,  6'd5);
    send_date(12'd2050, 4'd6,  5'd0,  5'd5,  6'd5,  6'd5);
    send_date(12'd2050, 4'd6,  5'd15, 5'd24, 6'd0,  6'd0);
    send_date(12'd2050, 4'd6,  5'd15, 5'd0,  6'd60, 6'd0);
    send_date(12'd2050, 4'd6,  5'd15, 5'd0,  6'd0,  6'd60);
    send_date(12'd2050, 4'd6,  5'd15, 5'd31, 6'd63, 6'd63);
    send_date(12'd2000, 4'd3,  5'd1,  5'd6,  6'd6,  6'd6);
    send_date(12'd2012, 4'd12, 5'd31, 5'd7,  6'd7,  6'd7);
    send_date(12'd2080, 4'd11, 5'd31, 5'd9,  6'd9,  6'd9);
    send_date(12'd2047, 4'd7,  5'd4,  5'd20, 6'd42, 6'd17);
  endtask

  task automatic test_valid_dates(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) shuffle_idling();
      send_valid_date();
    end
  endtask

  task automatic test_field_sweep(input int n);
    logic [11:0] y;
    logic [3:0]  m;
    logic [4:0]  d, h;
    logic [5:0]  mi, s;
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) shuffle_idling();
      y  = 12'($urandom);
      m  = 4'($urandom);
      d  = 5'($urandom);
      h  = 5'($urandom);
      mi = 6'($urandom);
      s  = 6'($urandom);
      case ($urandom_range(0, 3))
        0: ;
        1: y = 12'($urandom_range(YEAR_MIN, YEAR_MAX));
        2: begin
          // around the year limits with a plausible month and day
          y = 12'($urandom_range(1998, 2101));
          m = 4'($urandom_range(0, 13));
          d = 5'($urandom_range(0, 31));
        end
        default: begin
          y  = 12'($urandom_range(YEAR_MIN, YEAR_MAX));
          m  = 4'($urandom_range(MONTH_MIN, MONTH_MAX));
          d  = 5'($urandom_range(27, 31));
          h  = 5'($urandom_range(22, 25));
          mi = 6'($urandom_range(58, 61));
          s  = 6'($urandom_range(58, 61));
        end
      endcase
      send_date(y, m, d, h, mi, s);
    end
  endtask

  // output held off while the sender keeps going, so the block backs up
  task automatic test_receiver_hold();
    wait_drain();
    tx_idle_en = 1'b0;
    rx_hold    = 40;
    for (int i = 0; i < 30; i++) send_valid_date();
    tx_idle_en = 1'b1;
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 20; i++) send_valid_date();
    wait_drain();
    for (int i = 0; i < 20; i++) send_valid_date();
  endtask

  // receiver: per result a random hold-off, or a long one when asked
  initial begin
    int gap;
    wait (rst == 1'b0);
    forever begin
      gap = rx_idle_en ? $urandom_range(0, 4) : 0;
      if (rx_hold > 0) begin
        gap     = rx_hold;
        rx_hold = 0;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (date_checks_q.size() == 0) begin
        $error("result transfer with none expected: date_ok %0b time_ok %0b weekday %0d",
               date_ok, time_ok, weekday);
        n_mismatch++;
      end else begin
        want_chk = date_checks_q.pop_front();
        if (date_ok !== want_chk.date_ok) begin
          $error("date_ok: expected %0b, got %0b", want_chk.date_ok, date_ok);
          n_mismatch++;
        end
        if (time_ok !== want_chk.time_ok) begin
          $error("time_ok: expected %0b, got %0b", want_chk.time_ok, time_ok);
          n_mismatch++;
        end
        if (weekday !== want_chk.weekday) begin
          $error("weekday: expected %0d, got %0d", want_chk.weekday, weekday);
          n_mismatch++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_valid_dates(400);
    test_receiver_hold();
    test_field_sweep(400);
    test_drain_pause();
    test_valid_dates(300);
    wait_drain();
    repeat (8) @(posedge clk);
    if (n_mismatch == 0) begin
      $display("calendar_date_check_weekday_top: match");
    end else begin
      $display("calendar_date_check_weekday_top: mismatch");
    end
    $finish;
  end

endmodule
